FILE: sv/slt_pkg.sv
// Shared types and constants of the sink location table.
// No dependencies; every other file of the block but slt_ifs imports this package.
package slt_pkg;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // -1.0 in signed Q24.8
   localparam logic signed [31:0] MISS_COORD = 32'shFFFF_FF00;

   typedef struct packed {
      logic [1:0]         op;
      logic [15:0]        sink_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        prev_hop;
      logic [7:0]         hop_count;
      logic [15:0]        seq_no;
   } req_item_type;

   typedef struct packed {
      logic               ok;
      logic               table_full;
      logic signed [31:0] loc_x;
      logic signed [31:0] loc_y;
      logic [7:0]         hops_out;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0]        key;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        prev;
      logic [7:0]         hops;
      logic [15:0]        seq;
   } entry_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } tbl_cmd_type;

endpackage

FILE: sv/slt_ifs.sv
// Request and response channel interfaces of the sink location table.
// Valid/ready handshake; no dependencies.
interface slt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [15:0]        sink_id;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [15:0]        prev_hop;
   logic [7:0]         hop_count;
   logic [15:0]        seq_no;

   modport source (output valid, op, sink_id, pos_x, pos_y, prev_hop, hop_count, seq_no,
                   input ready);
   modport sink (input valid, op, sink_id, pos_x, pos_y, prev_hop, hop_count, seq_no,
                 output ready);
endinterface

interface slt_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic               table_full;
   logic signed [31:0] loc_x;
   logic signed [31:0] loc_y;
   logic [7:0]         hops_out;

   modport source (output valid, ok, table_full, loc_x, loc_y, hops_out, input ready);
   modport sink (input valid, ok, table_full, loc_x, loc_y, hops_out, output ready);
endinterface

FILE: sv/slt_table.sv
// Entry storage with parallel key compare and lowest-free-slot search.
// Depends on slt_pkg.
module slt_table import slt_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      lookup_key,
   output logic             hit,
   output logic [IDX_W-1:0] hit_idx,
   output entry_type        hit_entry,
   output logic             free_found,
   output logic [IDX_W-1:0] free_idx,
   input  tbl_cmd_type      cmd,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_entry
);

   logic [DEPTH-1:0] valid_ff;
   entry_type        entry_ff [DEPTH];

   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && (entry_ff[i].key == lookup_key)) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign hit_entry = entry_ff[hit_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (cmd.clr) begin
         valid_ff[wr_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

endmodule

FILE: sv/slt_exec.sv
// Per-transaction decision logic: update acceptance, remove, lookup result.
// Depends on slt_pkg; consumes the compare results of slt_table.
module slt_exec import slt_pkg::*; #(
   parameter int IDX_W = 4
) (
   input  req_item_type     item,
   input  logic             hit,
   input  logic [IDX_W-1:0] hit_idx,
   input  entry_type        hit_entry,
   input  logic             free_found,
   input  logic [IDX_W-1:0] free_idx,
   output tbl_cmd_type      cmd,
   output logic [IDX_W-1:0] wr_idx,
   output entry_type        wr_entry,
   output rsp_item_type     result
);

   logic same_pos;
   logic stale;

   assign same_pos = (hit_entry.x == item.pos_x) && (hit_entry.y == item.pos_y);
   assign stale    = (item.seq_no <= hit_entry.seq) || (hit_entry.hops <= item.hop_count);
   assign wr_idx   = hit ? hit_idx : free_idx;

   assign wr_entry = '{key:  item.sink_id,
                       x:    item.pos_x,
                       y:    item.pos_y,
                       prev: item.prev_hop,
                       hops: item.hop_count,
                       seq:  item.seq_no};

   always_comb begin
      cmd    = '0;
      result = '0;
      case (item.op)
         OP_UPDATE: begin
            if (hit) begin
               cmd.wr    = !(same_pos && stale);
               result.ok = !(same_pos && stale);
            end else begin
               cmd.wr            = free_found;
               result.ok         = free_found;
               result.table_full = !free_found;
            end
         end
         OP_REMOVE: begin
            cmd.clr   = hit;
            result.ok = hit;
         end
         OP_LOOKUP: begin
            result.ok = hit;
            if (hit) begin
               result.loc_x    = hit_entry.x;
               result.loc_y    = hit_entry.y;
               result.hops_out = hit_entry.hops;
            end else begin
               result.loc_x = MISS_COORD;
               result.loc_y = MISS_COORD;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

FILE: sv/sink_location_table_core.sv
// Sink location table: keyed store of sink id, Q24.8 position, last hop, hop count and
// sequence number, with update/insert, remove and lookup operations. A transaction is
// registered on acceptance, all keys are compared against it in parallel in the next cycle,
// and the table write and the result register load happen at the end of the cycle in which
// the result register is empty or being taken. The block sustains one transaction per clock
// while results are taken; a result passes the input register, the combinational compare and
// the result register. Valid bits clear on reset, so the table is usable after reset.
module sink_location_table_core import slt_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   slt_req_if.sink   req_if,
   slt_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic             s1_valid_ff, s1_valid_in;
   req_item_type     s1_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff;
   logic             req_take;
   logic             advance;

   logic             hit;
   logic [IDX_W-1:0] hit_idx;
   entry_type        hit_entry;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   tbl_cmd_type      exec_cmd;
   tbl_cmd_type      tbl_cmd;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_entry;
   rsp_item_type     result;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{op:        req_if.op,
                         sink_id:   req_if.sink_id,
                         pos_x:     req_if.pos_x,
                         pos_y:     req_if.pos_y,
                         prev_hop:  req_if.prev_hop,
                         hop_count: req_if.hop_count,
                         seq_no:    req_if.seq_no};
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   slt_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (s1_item_ff.sink_id),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .hit_entry  (hit_entry),
      .free_found (free_found),
      .free_idx   (free_idx),
      .cmd        (tbl_cmd),
      .wr_idx     (wr_idx),
      .wr_entry   (wr_entry)
   );

   slt_exec #(.IDX_W(IDX_W)) u_exec (
      .item       (s1_item_ff),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .hit_entry  (hit_entry),
      .free_found (free_found),
      .free_idx   (free_idx),
      .cmd        (exec_cmd),
      .wr_idx     (wr_idx),
      .wr_entry   (wr_entry),
      .result     (result)
   );

   // commit table changes only when the transaction moves to the result register
   assign tbl_cmd.wr  = exec_cmd.wr && advance;
   assign tbl_cmd.clr = exec_cmd.clr && advance;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ok         = rsp_item_ff.ok;
   assign rsp_if.table_full = rsp_item_ff.table_full;
   assign rsp_if.loc_x      = rsp_item_ff.loc_x;
   assign rsp_if.loc_y      = rsp_item_ff.loc_y;
   assign rsp_if.hops_out   = rsp_item_ff.hops_out;

endmodule

FILE: sv/slt_checker.sv
// Port-level assertions for sink_location_table_core and the bind that attaches them.
// Depends on slt_pkg and the top level.
module slt_checker import slt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               ok,
   input logic               table_full,
   input logic signed [31:0] loc_x,
   input logic signed [31:0] loc_y,
   input logic [7:0]         hops_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(ok) && $stable(table_full) && $stable(loc_x)
         && $stable(loc_y) && $stable(hops_out))
      else $error("response payload changed while stalled");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && table_full |-> !ok && (loc_x == 32'sd0) && (loc_y == 32'sd0)
         && (hops_out == 8'd0))
      else $error("table full reported with other result fields set");

   a_miss_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ok && (loc_x != 32'sd0) |-> (loc_x == MISS_COORD) && (loc_y == MISS_COORD)
         && (hops_out == 8'd0))
      else $error("malformed lookup miss");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sink_location_table_core slt_checker u_slt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .ok         (rsp_if.ok),
   .table_full (rsp_if.table_full),
   .loc_x      (rsp_if.loc_x),
   .loc_y      (rsp_if.loc_y),
   .hops_out   (rsp_if.hops_out)
);

FILE: sim/slt_checker.sv
`timescale 1ns / 1ps
// Transaction checker for the sink location table: watches both channels, keeps
// its own copy of the table and compares every result. Depends on slt_pkg and slt_ifs.
module slt_scoreboard import slt_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   slt_req_if   req_mon,
   slt_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);

   logic         live [TABLE_DEPTH];
   entry_type    slot [TABLE_DEPTH];
   rsp_item_type outcomes [$];

   function automatic rsp_item_type table_outcome(input req_item_type rq);
      rsp_item_type res;
      entry_type    fresh;
      int           hit;
      int           free_slot;
      int           target;
      logic         same_pos;
      logic         stale;
      logic         accept;
      res = '0;
      hit = -1;
      free_slot = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (live[i] && slot[i].key == rq.sink_id) hit = i;
         if (!live[i]) free_slot = i;
      end
      case (rq.op)
         OP_UPDATE: begin
            fresh = {rq.sink_id, rq.pos_x, rq.pos_y, rq.prev_hop, rq.hop_count, rq.seq_no};
            if (hit >= 0) begin
               same_pos = (slot[hit].x == rq.pos_x) && (slot[hit].y == rq.pos_y);
               stale = (rq.seq_no <= slot[hit].seq) || (slot[hit].hops <= rq.hop_count);
               accept = !(same_pos && stale);
               target = hit;
            end else begin
               accept = (free_slot >= 0);
               target = free_slot;
               res.table_full = !accept;
            end
            if (accept) begin
               slot[target] = fresh;
               live[target] = 1'b1;
            end
            res.ok = accept;
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               live[hit] = 1'b0;
               res.ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (hit >= 0) begin
               res.ok = 1'b1;
               res.loc_x = slot[hit].x;
               res.loc_y = slot[hit].y;
               res.hops_out = slot[hit].hops;
            end else begin
               res.loc_x = MISS_COORD;
               res.loc_y = MISS_COORD;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40)
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
         outcomes.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            outcomes.push_back(table_outcome({req_mon.op, req_mon.sink_id, req_mon.pos_x,
                                              req_mon.pos_y, req_mon.prev_hop,
                                              req_mon.hop_count, req_mon.seq_no}));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.ok, rsp_mon.table_full, rsp_mon.loc_x, rsp_mon.loc_y,
                   rsp_mon.hops_out};
            if (outcomes.size() == 0) begin
               report_mismatch("result with none pending", got.loc_x, '0);
            end else begin
               want = outcomes.pop_front();
               if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
               if (got.table_full !== want.table_full)
                  report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
               if (got.loc_x !== want.loc_x) report_mismatch("loc_x", got.loc_x, want.loc_x);
               if (got.loc_y !== want.loc_y) report_mismatch("loc_y", got.loc_y, want.loc_y);
               if (got.hops_out !== want.hops_out)
                  report_mismatch("hops_out", 32'(got.hops_out), 32'(want.hops_out));
            end
         end
      end
      pending <= outcomes.size();
   end

endmodule

FILE: sim/sink_location_table_core_tb.sv
`timescale 1ns / 1ps
// Top of the sink location table testbench: clock, reset, stimulus and verdict.
// Depends on slt_pkg, slt_ifs, sink_location_table_core and slt_scoreboard.
module sink_location_table_core_tb;
   import slt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL = 24;
   localparam int RANDOM_ITEMS = 500;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycles;
   int   hold_requests;
   int   holds_served;

   logic [15:0]        key_pool [POOL];
   logic signed [31:0] last_x [POOL];
   logic signed [31:0] last_y [POOL];
   logic [15:0]        last_seq [POOL];

   slt_req_if req_ch ();
   slt_rsp_if rsp_ch ();

   sink_location_table_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   slt_scoreboard u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[sink_location_table_core] ERROR");
         $finish;
      end
   end

   // receiver: random stalls, steady stretches, one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ((cycles / 400) % 3 != 0 && $urandom_range(0, 99) < 25)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   function automatic req_item_type make_req(input logic [1:0] op, input logic [15:0] id,
                                             input logic [31:0] x, input logic [31:0] y,
                                             input logic [15:0] prev, input logic [7:0] hops,
                                             input logic [15:0] seq);
      return {op, id, x, y, prev, hops, seq};
   endfunction

   function automatic logic [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 32'h8000_0000;
      if (r < 8) return 32'h7FFF_FFFF;
      if (r < 12) return MISS_COORD;
      if (r < 15) return '0;
      if (r < 60) return $urandom_range(0, 8191) - 4096;
      return $urandom;
   endfunction

   task automatic send_req(input req_item_type it, input logic steady);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 50);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= it.op;
      req_ch.sink_id <= it.sink_id;
      req_ch.pos_x <= it.pos_x;
      req_ch.pos_y <= it.pos_y;
      req_ch.prev_hop <= it.prev_hop;
      req_ch.hop_count <= it.hop_count;
      req_ch.seq_no <= it.seq_no;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      req_item_type it;
      int           r;
      int           pi;
      logic         steady;
      hold_requests = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_UPDATE;
      req_ch.sink_id = '0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.prev_hop = '0;
      req_ch.hop_count = '0;
      req_ch.seq_no = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, unused opcode, the acceptance rules on one id, then a second id and a remove
      send_req(make_req(OP_LOOKUP, 16'h0000, '0, '0, '0, '0, '0), 1'b1);
      send_req(make_req(OP_REMOVE, 16'h0000, '0, '0, '0, '0, '0), 1'b1);
      send_req(make_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                        8'hFF, 16'hFFFF), 1'b1);
      send_req(make_req(OP_UPDATE, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                        8'd255, 16'd0), 1'b1);
      send_req(make_req(OP_LOOKUP, 16'h0000, '0, '0, '0, '0, '0), 1'b1);
      send_req(make_req(OP_UPDATE, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h1111,
                        8'd0, 16'd0), 1'b1);
      send_req(make_req(OP_UPDATE, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h2222,
                        8'd255, 16'd5), 1'b1);
      send_req(make_req(OP_UPDATE, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h3333,
                        8'd10, 16'd5), 1'b1);
      send_req(make_req(OP_UPDATE, 16'h0000, MISS_COORD, 32'h0000_0100, 16'h4444,
                        8'd255, 16'd0), 1'b1);
      send_req(make_req(OP_UPDATE, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000,
                        8'd0, 16'hFFFF), 1'b1);
      send_req(make_req(OP_LOOKUP, 16'hFFFF, '0, '0, '0, '0, '0), 1'b1);
      send_req(make_req(OP_REMOVE, 16'h0000, '0, '0, '0, '0, '0), 1'b1);
      send_req(make_req(OP_LOOKUP, 16'h0000, '0, '0, '0, '0, '0), 1'b1);
      // fill every free slot, then overflow
      for (int k = 1; k < 16; k++)
         send_req(make_req(OP_UPDATE, 16'(k), 32'(k * 256), 32'(-k * 256), 16'(k),
                           8'(k), 16'(k)), 1'b0);
      send_req(make_req(OP_UPDATE, 16'h1234, '0, '0, '0, '0, '0), 1'b0);
      send_req(make_req(OP_LOOKUP, 16'h000F, '0, '0, '0, '0, '0), 1'b0);
      wait_drained();

      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int k = 2; k < POOL; k++) key_pool[k] = 16'($urandom_range(0, 65535));
      for (int k = 0; k < POOL; k++) begin
         last_x[k] = '0;
         last_y[k] = '0;
         last_seq[k] = '0;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_requests++;
         if (n == 320) wait_drained();
         steady = (n >= 150 && n < 200) || ((n / 60) % 3 == 0);
         r = $urandom_range(0, 99);
         pi = $urandom_range(0, POOL - 1);
         it.op = (r < 45) ? OP_UPDATE : (r < 70) ? OP_LOOKUP : (r < 92) ? OP_REMOVE
                                                                        : OP_UNUSED;
         it.sink_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[pi];
         it.pos_x = pick_coord();
         it.pos_y = pick_coord();
         it.prev_hop = 16'($urandom);
         it.hop_count = 8'($urandom);
         it.seq_no = 16'($urandom);
         if (it.op == OP_UPDATE && it.sink_id == key_pool[pi]) begin
            if ($urandom_range(0, 99) < 40) begin
               it.pos_x = last_x[pi];
               it.pos_y = last_y[pi];
            end
            if ($urandom_range(0, 4) != 0)
               it.seq_no = 16'(last_seq[pi] + $urandom_range(0, 4) - 2);
            last_x[pi] = it.pos_x;
            last_y[pi] = it.pos_y;
            last_seq[pi] = it.seq_no;
         end
         send_req(it, steady);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[sink_location_table_core] OK");
      else
         $display("[sink_location_table_core] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
sv/slt_pkg.sv
sv/slt_ifs.sv
sv/slt_table.sv
sv/slt_exec.sv
sv/sink_location_table_core.sv
sv/slt_checker.sv
sim/slt_checker.sv
sim/sink_location_table_core_tb.sv
